FILE: rtl/core/bounded_deque_with_reverse_defines.svh
// Assertion macros used by the checker file of the deque.
`ifndef BOUNDED_DEQUE_WITH_REVERSE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDR_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

FILE: rtl/core/bdr_pkg.sv
`default_nettype none

package bdr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_READ_FWD   = 3'd4,
      FUNC_READ_BWD   = 3'd5,
      FUNC_REVERSE    = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_HEAD,
      CELL_PUSH_TAIL,
      CELL_POP_HEAD,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_op_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      status_type         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      cell_op_type        op;
      logic [CNT_W-1:0]   count;
      logic signed [31:0] value;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/bounded_deque_with_reverse.sv
// Bounded double-ended queue of 16 signed 32-bit entries held in a row of cells.
// An item is offered on req_payload with start high and is taken at a clock edge
// where busy is low. The item carries an operation code and a push value.
// Results appear on rsp_payload for exactly one cycle, marked by rsp_strobe,
// in the cycle after the item is taken; the receiver cannot hold them off.
// Pushes, pops and reverse give one result and leave busy low, so a new item
// may follow in the next cycle. A read gives one result per stored entry,
// one per cycle, by rotating the occupied cells once around; busy stays high
// until the last of them has been issued. Reads and pops on an empty deque
// give one empty result; a push on a full deque is dropped and gives one full
// result. Reverse flips the direction flag. The reserved operation code is
// ignored and gives no result. Reset empties the deque, clears the direction
// flag and drops any read in progress; stored entry values are not cleared.
`default_nettype none

module bounded_deque_with_reverse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bdr_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output bdr_pkg::rsp_type      rsp_payload
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                   state_ff, state_in;
   logic [bdr_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [bdr_pkg::CNT_W-1:0]   remaining_ff, remaining_in;
   logic                        rev_ff, rev_in;
   logic                        backward_ff, backward_in;
   logic                        strobe_ff, strobe_in;
   bdr_pkg::rsp_type            rsp_ff, rsp_in;
   bdr_pkg::ctrl_type           ctrl;

   logic signed [31:0]          cell_data [bdr_pkg::DEPTH];
   logic signed [31:0]          head;
   logic signed [31:0]          tail;
   logic [bdr_pkg::CNT_W-1:0]   tail_pos;
   logic                        at_head;
   logic                        backward;

   assign tail_pos = count_ff - bdr_pkg::CNT_W'(1);
   assign head     = cell_data[0];
   assign tail     = cell_data[tail_pos[bdr_pkg::IDX_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      rev_in       = rev_ff;
      backward_in  = backward_ff;
      strobe_in    = 1'b0;
      rsp_in       = '0;
      ctrl.op      = bdr_pkg::CELL_HOLD;
      ctrl.count   = count_ff;
      ctrl.value   = req_payload.value;
      at_head      = 1'b0;
      backward     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_payload.func)
                  bdr_pkg::FUNC_PUSH_FRONT, bdr_pkg::FUNC_PUSH_BACK: begin
                     strobe_in   = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff == bdr_pkg::CNT_W'(bdr_pkg::DEPTH)) begin
                        rsp_in.status = bdr_pkg::STATUS_FULL;
                     end else begin
                        at_head  = (req_payload.func == bdr_pkg::FUNC_PUSH_FRONT) != rev_ff;
                        ctrl.op  = at_head ? bdr_pkg::CELL_PUSH_HEAD
                                           : bdr_pkg::CELL_PUSH_TAIL;
                        count_in = count_ff + bdr_pkg::CNT_W'(1);
                     end
                  end
                  bdr_pkg::FUNC_POP_FRONT, bdr_pkg::FUNC_POP_BACK: begin
                     strobe_in   = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in.status = bdr_pkg::STATUS_EMPTY;
                     end else begin
                        at_head          = (req_payload.func == bdr_pkg::FUNC_POP_FRONT) != rev_ff;
                        rsp_in.value_out = at_head ? head : tail;
                        ctrl.op          = at_head ? bdr_pkg::CELL_POP_HEAD
                                                   : bdr_pkg::CELL_HOLD;
                        count_in         = count_ff - bdr_pkg::CNT_W'(1);
                     end
                  end
                  bdr_pkg::FUNC_READ_FWD, bdr_pkg::FUNC_READ_BWD: begin
                     strobe_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in.status = bdr_pkg::STATUS_EMPTY;
                        rsp_in.last   = 1'b1;
                     end else begin
                        backward         = (req_payload.func == bdr_pkg::FUNC_READ_BWD) != rev_ff;
                        rsp_in.value_out = backward ? tail : head;
                        ctrl.op          = backward ? bdr_pkg::CELL_ROT_RIGHT
                                                    : bdr_pkg::CELL_ROT_LEFT;
                        ctrl.value       = backward ? tail : head;
                        rsp_in.last      = (count_ff == bdr_pkg::CNT_W'(1));
                        backward_in      = backward;
                        remaining_in     = count_ff - bdr_pkg::CNT_W'(1);
                        if (count_ff != bdr_pkg::CNT_W'(1)) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  bdr_pkg::FUNC_REVERSE: begin
                     strobe_in   = 1'b1;
                     rsp_in.last = 1'b1;
                     rev_in      = !rev_ff;
                  end
                  default: begin
                     strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            strobe_in        = 1'b1;
            rsp_in.value_out = backward_ff ? tail : head;
            ctrl.op          = backward_ff ? bdr_pkg::CELL_ROT_RIGHT
                                           : bdr_pkg::CELL_ROT_LEFT;
            ctrl.value       = backward_ff ? tail : head;
            rsp_in.last      = (remaining_ff == bdr_pkg::CNT_W'(1));
            remaining_in     = remaining_ff - bdr_pkg::CNT_W'(1);
            if (remaining_ff == bdr_pkg::CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remaining_ff <= '0;
         rev_ff       <= 1'b0;
         backward_ff  <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rev_ff       <= rev_in;
         backward_ff  <= backward_in;
         strobe_ff    <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < bdr_pkg::DEPTH; i++) begin : g_cell
      localparam logic [bdr_pkg::IDX_W-1:0] SLOT = bdr_pkg::IDX_W'(i);
      logic signed [31:0] left_in;
      logic signed [31:0] right_in;

      if (i == 0) begin : g_first
         assign left_in = ctrl.value;
      end else begin : g_inner_left
         assign left_in = cell_data[i-1];
      end

      if (i == bdr_pkg::DEPTH - 1) begin : g_final
         assign right_in = ctrl.value;
      end else begin : g_inner_right
         assign right_in = cell_data[i+1];
      end

      bdr_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .slot     (SLOT),
         .left_in  (left_in),
         .right_in (right_in),
         .data_out (cell_data[i])
      );
   end

   assign busy        = (state_ff == ST_READ);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bdr_cell.sv
`default_nettype none

module bdr_cell (
   input  wire logic                       clock,
   input  wire bdr_pkg::ctrl_type          ctrl,
   input  wire logic [bdr_pkg::IDX_W-1:0]  slot,
   input  wire logic signed [31:0]         left_in,
   input  wire logic signed [31:0]         right_in,
   output logic signed [31:0]              data_out
);

   logic signed [31:0]          data_ff;
   logic signed [31:0]          data_in;
   logic [bdr_pkg::CNT_W-1:0]   slot_ext;
   logic [bdr_pkg::CNT_W-1:0]   last_pos;

   assign slot_ext = bdr_pkg::CNT_W'(slot);
   assign last_pos = ctrl.count - bdr_pkg::CNT_W'(1);

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         bdr_pkg::CELL_PUSH_HEAD: begin
            data_in = left_in;
         end
         bdr_pkg::CELL_PUSH_TAIL: begin
            if (slot_ext == ctrl.count) begin
               data_in = ctrl.value;
            end
         end
         bdr_pkg::CELL_POP_HEAD: begin
            data_in = right_in;
         end
         bdr_pkg::CELL_ROT_LEFT: begin
            if (slot_ext == last_pos) begin
               data_in = ctrl.value;
            end else if (slot_ext < last_pos) begin
               data_in = right_in;
            end
         end
         bdr_pkg::CELL_ROT_RIGHT: begin
            if (slot_ext < ctrl.count) begin
               data_in = left_in;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bdr_checker.sv
`default_nettype none
`include "bounded_deque_with_reverse_defines.svh"

module bdr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire bdr_pkg::req_type req_payload,
   input wire logic             rsp_strobe,
   input wire bdr_pkg::rsp_type rsp_payload
);

   logic taken_op;
   logic error_seen;
   logic single_zero;

   assign taken_op = start && !busy && (req_payload.func == bdr_pkg::FUNC_PUSH_FRONT
      || req_payload.func == bdr_pkg::FUNC_PUSH_BACK
      || req_payload.func == bdr_pkg::FUNC_POP_FRONT
      || req_payload.func == bdr_pkg::FUNC_POP_BACK
      || req_payload.func == bdr_pkg::FUNC_READ_FWD
      || req_payload.func == bdr_pkg::FUNC_READ_BWD
      || req_payload.func == bdr_pkg::FUNC_REVERSE);

   assign error_seen  = rsp_strobe && (rsp_payload.status != bdr_pkg::STATUS_OK);
   assign single_zero = rsp_payload.last && (rsp_payload.value_out == 32'sd0);

   `BDR_ASSERT_NEXT(a_item_answered, clock, reset, taken_op, rsp_strobe)
   `BDR_ASSERT_SAME(a_busy_streams, clock, reset, busy, rsp_strobe && !rsp_payload.last)
   `BDR_ASSERT_SAME(a_read_ends_last, clock, reset, $fell(busy), rsp_strobe && rsp_payload.last)
   `BDR_ASSERT_SAME(a_error_single, clock, reset, error_seen, single_zero)

endmodule

bind bounded_deque_with_reverse bdr_checker u_bdr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

FILE: dv/bounded_deque_with_reverse_tb.sv
`timescale 1ns / 1ps

module bounded_deque_with_reverse_tb;
   import bdr_pkg::*;

   localparam logic [2:0] FUNC_RESERVED = 3'd7;
   localparam int TIMEOUT_NS = 2_000_000;
   localparam int SETTLE_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   logic signed [31:0] ring_store [DEPTH];
   logic [IDX_W-1:0]   ring_head = '0;
   logic [CNT_W-1:0]   ring_fill = '0;
   logic               ring_flipped = 1'b0;
   rsp_type            awaited_rsp [$];

   int idle_pct = 0;
   int items_sent = 0;
   int ignored_count = 0;
   int results_checked = 0;
   int full_seen = 0;
   int empty_seen = 0;
   int mismatch_count = 0;

   always #5 clock = ~clock;

   bounded_deque_with_reverse uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   function automatic logic [IDX_W-1:0] slot_at(input int k);
      return IDX_W'((int'(ring_head) + k) % DEPTH);
   endfunction

   function automatic void note_result(input logic signed [31:0] v, input status_type st,
                                       input logic l);
      rsp_type r;
      r.value_out = v;
      r.status = st;
      r.last = l;
      awaited_rsp.push_back(r);
   endfunction

   // Updates the deque image for one accepted item and queues the results it causes.
   function automatic void apply_op(input logic [2:0] code, input logic signed [31:0] val);
      int lp;
      int off;
      int fill;
      logic at_front;
      logic signed [31:0] v;
      fill = int'(ring_fill);
      case (code)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               note_result('0, STATUS_FULL, 1'b1);
            end else begin
               at_front = (code == FUNC_PUSH_FRONT);
               if (at_front != ring_flipped) begin
                  ring_head = IDX_W'((int'(ring_head) + DEPTH - 1) % DEPTH);
                  ring_store[ring_head] = val;
               end else begin
                  ring_store[slot_at(fill)] = val;
               end
               ring_fill = ring_fill + 1'b1;
               note_result('0, STATUS_OK, 1'b1);
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (fill == 0) begin
               note_result('0, STATUS_EMPTY, 1'b1);
            end else begin
               at_front = (code == FUNC_POP_FRONT);
               if (at_front != ring_flipped) begin
                  v = ring_store[ring_head];
                  ring_head = IDX_W'((int'(ring_head) + 1) % DEPTH);
               end else begin
                  v = ring_store[slot_at(fill - 1)];
               end
               ring_fill = ring_fill - 1'b1;
               note_result(v, STATUS_OK, 1'b1);
            end
         end
         FUNC_READ_FWD, FUNC_READ_BWD: begin
            if (fill == 0) begin
               note_result('0, STATUS_EMPTY, 1'b1);
            end else begin
               for (int p = 0; p < fill; p++) begin
                  lp = (code == FUNC_READ_FWD) ? p : fill - 1 - p;
                  off = ring_flipped ? fill - 1 - lp : lp;
                  note_result(ring_store[slot_at(off)], STATUS_OK, p == fill - 1);
               end
            end
         end
         FUNC_REVERSE: begin
            ring_flipped = ~ring_flipped;
            note_result('0, STATUS_OK, 1'b1);
         end
         default: begin
            ignored_count++;
         end
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         req_payload <= {3'($urandom), 32'($urandom)};
      end
   endtask

   task automatic issue_op(input logic [2:0] code, input logic signed [31:0] val);
      @(negedge clock);
      start <= 1'b1;
      req_payload <= {code, val};
      do @(posedge clock); while (busy);
      apply_op(code, val);
      items_sent++;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_checked++;
         if (awaited_rsp.size() == 0) begin
            $error("unexpected result: value_out %0d status %0d last %0b",
                   rsp_payload.value_out, rsp_payload.status, rsp_payload.last);
            mismatch_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (want.status == STATUS_FULL) full_seen++;
            if (want.status == STATUS_EMPTY) empty_seen++;
            if (rsp_payload.value_out !== want.value_out) begin
               $error("value_out expected %0d, got %0d", want.value_out, rsp_payload.value_out);
               mismatch_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d, got %0d", want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last expected %0b, got %0b", want.last, rsp_payload.last);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_empty_deque();
      idle_pct = 0;
      issue_op(FUNC_POP_FRONT, 32'sd5);
      issue_op(FUNC_POP_BACK, -32'sd5);
      issue_op(FUNC_READ_FWD, 32'sd0);
      issue_op(FUNC_READ_BWD, 32'sd0);
      issue_op(FUNC_REVERSE, 32'sd0);
      issue_op(FUNC_RESERVED, 32'sh12345678);
   endtask

   // Starts in reversed order, so pushes land at the opposite physical ends.
   task automatic test_fill_and_overflow();
      idle_pct = 0;
      issue_op(FUNC_PUSH_FRONT, 32'sh7FFFFFFF);
      issue_op(FUNC_PUSH_BACK, 32'sh80000000);
      for (int i = 0; i < 14; i++) begin
         if (i == 7) issue_op(FUNC_REVERSE, 32'sd0);
         issue_op((i % 2) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                  (i % 2) ? -32'sd1 - i : 32'sh5A5A0000 + i);
      end
      issue_op(FUNC_PUSH_FRONT, 32'sd1);
      issue_op(FUNC_PUSH_BACK, 32'sd2);
      issue_op(FUNC_READ_FWD, 32'sd0);
      issue_op(FUNC_READ_BWD, 32'sd0);
      issue_op(FUNC_POP_FRONT, 32'sd0);
      issue_op(FUNC_POP_BACK, 32'sd0);
      issue_op(FUNC_REVERSE, 32'sd0);
      issue_op(FUNC_READ_FWD, 32'sd0);
   endtask

   // Runs of sixteen items lean toward filling, draining or a balanced mix.
   task automatic test_random_traffic(input int pct, input int n_items);
      int lean;
      int r;
      int push_cut;
      int pop_cut;
      logic [2:0] code;
      idle_pct = pct;
      lean = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 16 == 0) lean = $urandom_range(2);
         push_cut = (lean == 0) ? 65 : (lean == 1) ? 15 : 40;
         pop_cut = push_cut + ((lean == 1) ? 55 : 25);
         r = $urandom_range(99);
         if (r < push_cut)
            code = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
         else if (r < pop_cut)
            code = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
         else if (r < 90)
            code = $urandom_range(1) ? FUNC_READ_BWD : FUNC_READ_FWD;
         else if (r < 98)
            code = FUNC_REVERSE;
         else
            code = FUNC_RESERVED;
         idle_gap();
         issue_op(code, pick_value());
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_deque();
      test_fill_and_overflow();
      test_random_traffic(0, 47);
      test_random_traffic(80, 47);
      test_random_traffic(37, 47);
      drain_results();
      $display("Sent %0d items covering every operation, %0d of them with the reserved code.",
               items_sent, ignored_count);
      $display("Checked %0d results, %0d of them full and %0d of them empty.",
               results_checked, full_seen, empty_seen);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bdr_pkg.sv
rtl/core/bdr_cell.sv
rtl/core/bounded_deque_with_reverse.sv
rtl/core/bdr_checker.sv
dv/bounded_deque_with_reverse_tb.sv
